// ----- src/upd_pkg.sv -----
package upd_pkg;

  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChPct   = 8'h25;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } upd_phase_e;

  // One queue entry: every result that one input byte produced.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      count;     // number of results, 1 to 3
    logic            bare;      // end marker with no byte
    logic            text_end;
  } upd_entry_t;

  // {is_hex, nibble}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

endpackage

// ----- src/upd_if.sv -----
interface upd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_last;
  modport source (output valid, output in_byte, output is_last, input ready);
  modport sink   (input valid, input in_byte, input is_last, output ready);
endinterface

interface upd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       run_last;
  logic       text_end;
  modport source (output valid, output out_byte, output byte_valid, output run_last,
                  output text_end, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input run_last,
                  input text_end, output ready);
endinterface

// ----- src/url_percent_decoder.sv -----
// channel | dir | payload                                     | carries
// in_i    | in  | in_byte[7:0], is_last                       | one text byte per beat
// out_o   | out | out_byte[7:0], byte_valid, run_last, text_end | one decoded result per beat
//
// Takes one byte per cycle while the entry queue is not full; an accepted byte's results
// pass through the entry queue into the output register. The output stage emits one result
// per cycle while the sink is ready, so a byte that yields two or three results (broken escape,
// flush at end of text) holds the output side per result; the entry queue absorbs it.
// rst_ni clears the escape state, the queue pointers and the output valid.
module url_percent_decoder #(
  parameter int QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  upd_in_if.sink     in_i,
  upd_out_if.source  out_o
);

  upd_pkg::upd_entry_t push_entry, head_entry;
  logic                push, pop, full, empty;

  upd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (full),
    .push_o   (push),
    .entry_o  (push_entry)
  );

  upd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .head_o  (head_entry),
    .empty_o (empty)
  );

  upd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head_entry),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

// ----- src/upd_front.sv -----
module upd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  upd_in_if.sink              in_i,
  input  logic                q_full_i,
  output logic                push_o,
  output upd_pkg::upd_entry_t entry_o
);

  upd_pkg::upd_phase_e phase_q, phase_d;
  logic [7:0]          held_q, held_d;

  logic [2:0][7:0] bytes;
  logic [1:0]      n;
  logic            replay;
  logic [4:0]      hv, hi;
  logic            accept;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && !q_full_i;

  always_comb begin
    bytes   = '0;
    n       = 2'd0;
    replay  = 1'b0;
    phase_d = upd_pkg::PH_IDLE;
    held_d  = held_q;
    hv      = upd_pkg::hex_val(in_i.in_byte);
    hi      = upd_pkg::hex_val(held_q);

    unique case (phase_q)
      upd_pkg::PH_PCT: begin
        if (hv[4]) begin
          held_d  = in_i.in_byte;
          phase_d = upd_pkg::PH_DIGIT;
        end else begin
          bytes[n] = upd_pkg::ChPct;
          n        = n + 2'd1;
          replay   = 1'b1;
        end
      end
      upd_pkg::PH_DIGIT: begin
        held_d = 8'h00;
        if (hv[4]) begin
          // decoded carriage return is dropped
          if ({hi[3:0], hv[3:0]} != upd_pkg::ChCr) begin
            bytes[n] = {hi[3:0], hv[3:0]};
            n        = n + 2'd1;
          end
        end else begin
          bytes[n] = upd_pkg::ChPct;
          n        = n + 2'd1;
          bytes[n] = held_q;
          n        = n + 2'd1;
          replay   = 1'b1;
        end
      end
      default: replay = 1'b1;
    endcase

    if (replay) begin
      if (in_i.in_byte == upd_pkg::ChPct) begin
        phase_d = upd_pkg::PH_PCT;
      end else begin
        bytes[n] = (in_i.in_byte == upd_pkg::ChPlus) ? upd_pkg::ChSpace : in_i.in_byte;
        n        = n + 2'd1;
      end
    end

    // flush a pending escape at end of text
    if (in_i.is_last) begin
      if (phase_d == upd_pkg::PH_PCT) begin
        bytes[n] = upd_pkg::ChPct;
        n        = n + 2'd1;
      end else if (phase_d == upd_pkg::PH_DIGIT) begin
        bytes[n] = upd_pkg::ChPct;
        n        = n + 2'd1;
        bytes[n] = held_d;
        n        = n + 2'd1;
      end
      phase_d = upd_pkg::PH_IDLE;
      held_d  = 8'h00;
    end

    entry_o.bytes    = bytes;
    entry_o.bare     = (n == 2'd0);
    entry_o.count    = (n == 2'd0) ? 2'd1 : n;
    entry_o.text_end = in_i.is_last;
    push_o           = accept && ((n != 2'd0) || in_i.is_last);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= upd_pkg::PH_IDLE;
      held_q  <= 8'h00;
    end else if (accept) begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

endmodule

// ----- src/upd_fifo.sv -----
module upd_fifo #(
  parameter int Depth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  upd_pkg::upd_entry_t data_i,
  output logic                full_o,
  input  logic                pop_i,
  output upd_pkg::upd_entry_t head_o,
  output logic                empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  upd_pkg::upd_entry_t mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- src/upd_back.sv -----
module upd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  upd_pkg::upd_entry_t head_i,
  input  logic                empty_i,
  output logic                pop_o,
  upd_out_if.source           out_o
);

  logic [1:0] idx_q;
  logic       valid_q;
  logic [7:0] byte_q;
  logic       byte_valid_q, run_last_q, text_end_q;
  logic       load, final_res;

  assign load      = !empty_i && (!valid_q || out_o.ready);
  assign final_res = (idx_q == head_i.count - 2'd1);
  assign pop_o     = load && final_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= final_res ? 2'd0 : idx_q + 2'd1;
      end else if (out_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q       <= head_i.bare ? 8'h00 : head_i.bytes[idx_q];
      byte_valid_q <= !head_i.bare;
      run_last_q   <= final_res;
      text_end_q   <= final_res && head_i.text_end;
    end
  end

  assign out_o.valid      = valid_q;
  assign out_o.out_byte   = byte_q;
  assign out_o.byte_valid = byte_valid_q;
  assign out_o.run_last   = run_last_q;
  assign out_o.text_end   = text_end_q;

endmodule
